>>> design/skt_pkg.sv
// skt_pkg: shared types and codes for the smallest-k tracker
// beat structs for the request and response channels, opcode values
// no dependencies
package skt_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef struct packed {
		logic                       opcode;
		logic signed [VALUE_W-1:0]  value;
		logic        [COUNT_W-1:0]  count;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  value_res;
		logic                       valid_res;
		logic                       last;
	} rsp_t;

endpackage

>>> design/smallest_k_tracker_unit.sv
// smallest_k_tracker_unit: keeps the CAPACITY smallest values inserted, sorted ascending
// one single-port-write memory, one shared signed compare, small sequencer
// depends on skt_pkg
//
//  channel | direction | flow control       | beat
//  --------+-----------+--------------------+--------------------------------
//  req     | in        | req_valid/req_stall| opcode, value, count (req_t)
//  rsp     | out       | rsp_valid/rsp_stall| value_res, valid_res, last (rsp_t)
//
// insert: into an empty store the value is written in the accept cycle, else one entry
//   is shifted up per step; a full store first compares against its largest entry (a
//   dropped value ends there); the loop is read entry, compare, write it one up
// query: accept, then per result beat a memory read, then a load of the output register,
//   which waits while rsp is full; an empty answer is loaded in the accept cycle
// reset clears the fill count, sequencer and output register, not the store; the store needs no clearing pass
// req_stall is high while the sequencer is busy, and for a query while rsp is full
module smallest_k_tracker_unit import skt_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);     // store address width
	localparam int CW = $clog2(CAPACITY + 1); // fill count width

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_TOP,    // compare new value against the largest of a full store
		ST_INS_SHIFT,  // compare against entry idx-1, shift it up or drop value in
		ST_INS_PUT,    // value lands in entry 0
		ST_Q_RD,       // read entry k
		ST_Q_LD        // move read data into the output register
	} state_t;

	state_t                    state_q;
	logic   [AW-1:0]           idx_q;     // insertion slot / write address
	logic   [AW-1:0]           k_q;       // query read index
	logic   [CW-1:0]           held_q;    // number of valid entries
	logic   [CW-1:0]           n_q;       // beats this query gives
	logic signed [VALUE_W-1:0] val_q;     // value being inserted
	logic signed [VALUE_W-1:0] rd_q;      // registered memory read data
	logic signed [VALUE_W-1:0] store_q [CAPACITY];
	rsp_t                      rsp_q;
	logic                      rsp_valid_q;

	// memory port controls
	logic                      mem_we;
	logic   [AW-1:0]           mem_wa;
	logic signed [VALUE_W-1:0] mem_wd;
	logic                      mem_re;
	logic   [AW-1:0]           mem_ra;

	logic                      req_acc;
	logic                      out_free;
	logic                      full;
	logic                      greater;   // shared compare: stored entry above new value
	logic                      q_last;
	logic   [COUNT_W-1:0]      q_num;
	logic                      rsp_load;  // output register takes a new beat this cycle

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign full      = (held_q == CW'(CAPACITY));
	assign req_stall = (state_q != ST_IDLE) || (!out_free && req.opcode == OP_QUERY);
	assign req_acc   = req_valid && !req_stall;
	assign greater   = (rd_q > val_q);
	assign q_last    = ((CW'(k_q) + CW'(1)) == n_q);
	// clip the request to what is held
	assign q_num     = (req.count < COUNT_W'(held_q)) ? req.count : COUNT_W'(held_q);
	assign rsp_load  = (req_acc && req.opcode == OP_QUERY && q_num == '0)
		|| (state_q == ST_Q_LD && out_free);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// memory port steering
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = val_q;
		mem_re = 1'b0;
		mem_ra = k_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc && req.opcode == OP_INSERT) begin
					if (held_q == '0) begin
						mem_we = 1'b1;
						mem_wa = '0;
						mem_wd = req.value;
					end else if (full) begin
						mem_re = 1'b1;
						mem_ra = AW'(CAPACITY - 1);
					end else begin
						mem_re = 1'b1;
						mem_ra = AW'(held_q - CW'(1));
					end
				end
			end
			ST_INS_TOP: begin
				if (greater) begin
					mem_re = 1'b1;
					mem_ra = AW'(CAPACITY - 2);
				end
			end
			ST_INS_SHIFT: begin
				mem_we = 1'b1;
				mem_wa = idx_q;
				if (greater) begin
					mem_wd = rd_q;
					if (idx_q != AW'(1)) begin
						mem_re = 1'b1;
						mem_ra = idx_q - AW'(2);
					end
				end
			end
			ST_INS_PUT: begin
				mem_we = 1'b1;
				mem_wa = '0;
			end
			ST_Q_RD: begin
				mem_re = 1'b1;
				mem_ra = k_q;
			end
			ST_Q_LD: begin
			end
			default: begin
			end
		endcase
	end

	// store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= store_q[mem_ra];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
			k_q         <= '0;
			n_q         <= '0;
			val_q       <= '0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						val_q <= req.value;
						if (req.opcode == OP_INSERT) begin
							if (held_q == '0) begin
								held_q <= CW'(1);
							end else if (full) begin
								state_q <= ST_INS_TOP;
							end else begin
								idx_q   <= AW'(held_q);
								state_q <= ST_INS_SHIFT;
							end
						end else if (q_num == '0) begin
							// empty answer: one beat, no data
							rsp_q.value_res <= '0;
							rsp_q.valid_res <= 1'b0;
							rsp_q.last      <= 1'b1;
							rsp_valid_q     <= 1'b1;
						end else begin
							n_q     <= CW'(q_num);
							k_q     <= '0;
							state_q <= ST_Q_RD;
						end
					end
				end
				ST_INS_TOP: begin
					if (greater) begin
						// evict the largest; start shifting below it
						idx_q   <= AW'(CAPACITY - 1);
						state_q <= ST_INS_SHIFT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_INS_SHIFT: begin
					if (greater) begin
						idx_q <= idx_q - AW'(1);
						if (idx_q == AW'(1)) begin
							state_q <= ST_INS_PUT;
						end
					end else begin
						if (!full) begin
							held_q <= held_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_INS_PUT: begin
					if (!full) begin
						held_q <= held_q + CW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_Q_RD: begin
					state_q <= ST_Q_LD;
				end
				ST_Q_LD: begin
					if (out_free) begin
						rsp_q.value_res <= rd_q;
						rsp_q.valid_res <= 1'b1;
						rsp_q.last      <= q_last;
						rsp_valid_q     <= 1'b1;
						if (q_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= ST_Q_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// fill count never passes the capacity
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// fill count only ever grows by one
	a_held_step: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != $past(held_q) |-> held_q == $past(held_q) + CW'(1))
		else $error("fill count jumped");

	// a pending beat that is not the last one belongs to a running query
	a_query_open: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.last |-> (state_q == ST_Q_RD || state_q == ST_Q_LD))
		else $error("non-final beat outside a query");
`endif

endmodule
